/* rtl/gpm_pkg.sv */
package gpm_pkg;

   // pattern syntax characters
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_ESC    = 8'h5C;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_NUL    = 8'h00;

   localparam int LEN_W = 6;

   typedef struct packed {
      logic       start;
      logic [7:0] char;
   } gpm_cmd_type;

   typedef struct packed {
      logic fire;
      logic matched;
   } gpm_result_type;

endpackage

/* rtl/gpm_pat_mem.sv */
module gpm_pat_mem #(
   parameter int DEPTH = 32,
   parameter int AW    = 5,
   parameter int PW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [PW-1:0] rd_addr,
   input  logic [PW-1:0] used,
   output logic [7:0]    rd_data
);
   import gpm_pkg::*;

   logic [7:0] pat_mem [DEPTH];
   logic [7:0] q_ff;
   logic       past_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pat_mem[wr_addr] <= wr_data;
      end
      q_ff    <= pat_mem[rd_addr[AW-1:0]];
      past_ff <= (rd_addr >= used);
   end

   // positions past the used length read as pattern end
   assign rd_data = past_ff ? CH_NUL : q_ff;

endmodule

/* rtl/gpm_engine.sv */
module gpm_engine #(
   parameter int MAX_PATTERN = 32,
   parameter int PW          = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gpm_pkg::gpm_cmd_type    cmd,
   input  logic                    out_free,
   output logic [PW-1:0]           rd_addr,
   input  logic [7:0]              rd_data,
   output logic                    idle,
   output gpm_pkg::gpm_result_type result
);
   import gpm_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_HEAD   = 4'd2;
   localparam logic [3:0] S_ESC    = 4'd3;
   localparam logic [3:0] S_CBANG  = 4'd4;
   localparam logic [3:0] S_CA     = 4'd5;
   localparam logic [3:0] S_CB     = 4'd6;
   localparam logic [3:0] S_CSCAN  = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   localparam logic [PW-1:0] LAST_POS = PW'(MAX_PATTERN);
   localparam logic [PW-1:0] ONE      = PW'(1);
   localparam logic [PW-1:0] TWO      = PW'(2);

   logic [3:0]         state_ff, state_in;
   logic [PW-1:0]      k_ff, k_in;
   logic [PW-1:0]      i_ff, i_in;
   logic [PW-1:0]      j_ff, j_in;
   logic [7:0]         c_ff, c_in;
   logic [7:0]         lo_ff, lo_in;
   logic [7:0]         pj_ff, pj_in;
   logic               dot_ff, dot_in;
   logic               start_ff, start_in;
   logic               match_ff, match_in;
   logic               skip_ff, skip_in;
   logic               neg_ff, neg_in;
   logic               hit_ff, hit_in;
   logic               first_ff, first_in;
   logic [MAX_PATTERN:0] active_ff, active_in;
   logic [MAX_PATTERN:0] next_ff, next_in;
   logic               thread_end;
   logic               block_wild;

   assign block_wild = dot_ff || (c_ff == CH_NUL);

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      c_in       = c_ff;
      lo_in      = lo_ff;
      pj_in      = pj_ff;
      dot_in     = dot_ff;
      start_in   = start_ff;
      match_in   = match_ff;
      skip_in    = skip_ff;
      neg_in     = neg_ff;
      hit_in     = hit_ff;
      first_in   = first_ff;
      active_in  = active_ff;
      next_in    = next_ff;
      rd_addr    = i_ff;
      thread_end = 1'b0;
      result     = '0;

      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               c_in     = cmd.char;
               dot_in   = start_ff && (cmd.char == CH_DOT);
               k_in     = '0;
               next_in  = '0;
               match_in = 1'b0;
               state_in = S_SCAN;
            end
         end

         // pick the next active thread
         S_SCAN: begin
            if (active_ff[k_ff]) begin
               i_in     = k_ff;
               skip_in  = 1'b0;
               rd_addr  = k_ff;
               state_in = S_HEAD;
            end else begin
               thread_end = 1'b1;
            end
         end

         // dispatch on the pattern byte at i
         S_HEAD: begin
            skip_in = 1'b0;
            case (rd_data)
               CH_STAR: begin
                  if (skip_ff) begin
                     i_in    = i_ff + ONE;
                     rd_addr = i_ff + ONE;
                     skip_in = 1'b1;
                  end else if (dot_ff) begin
                     thread_end = 1'b1;
                  end else begin
                     next_in[i_ff] = 1'b1;
                     i_in    = i_ff + ONE;
                     rd_addr = i_ff + ONE;
                     skip_in = 1'b1;
                  end
               end
               CH_QUEST: begin
                  if (!block_wild) begin
                     next_in[i_ff + ONE] = 1'b1;
                  end
                  thread_end = 1'b1;
               end
               CH_LBRACK: begin
                  if (block_wild) begin
                     thread_end = 1'b1;
                  end else begin
                     rd_addr  = i_ff + ONE;
                     state_in = S_CBANG;
                  end
               end
               CH_ESC: begin
                  i_in     = i_ff + ONE;
                  rd_addr  = i_ff + ONE;
                  state_in = S_ESC;
               end
               default: begin
                  if (rd_data == c_ff) begin
                     if (c_ff != CH_NUL) begin
                        next_in[i_ff + ONE] = 1'b1;
                     end else begin
                        match_in = 1'b1;
                     end
                  end
                  thread_end = 1'b1;
               end
            endcase
         end

         // literal after an escape
         S_ESC: begin
            if (rd_data == c_ff) begin
               if (c_ff != CH_NUL) begin
                  next_in[i_ff + ONE] = 1'b1;
               end else begin
                  match_in = 1'b1;
               end
            end
            thread_end = 1'b1;
         end

         // class opener: check for negation
         S_CBANG: begin
            first_in = 1'b1;
            hit_in   = 1'b0;
            lo_in    = 8'h00;
            if (rd_data == CH_BANG) begin
               neg_in  = 1'b1;
               j_in    = i_ff + TWO;
               rd_addr = i_ff + TWO;
            end else begin
               neg_in  = 1'b0;
               j_in    = i_ff + ONE;
               rd_addr = i_ff + ONE;
            end
            state_in = S_CA;
         end

         // class body: byte at j
         S_CA: begin
            pj_in = rd_data;
            if (!hit_ff && (rd_data != CH_NUL) && (first_ff || (rd_data != CH_RBRACK))) begin
               rd_addr  = j_ff + ONE;
               state_in = S_CB;
            end else if (rd_data == CH_NUL) begin
               thread_end = 1'b1;
            end else if (rd_data == CH_RBRACK) begin
               if (hit_ff != neg_ff) begin
                  next_in[j_ff + ONE] = 1'b1;
               end
               thread_end = 1'b1;
            end else begin
               j_in     = j_ff + ONE;
               rd_addr  = j_ff + ONE;
               state_in = S_CSCAN;
            end
         end

         // class body: lookahead byte at j+1
         S_CB: begin
            if ((pj_ff == CH_DASH) && (lo_ff != 8'h00) && !first_ff
                && (rd_data != CH_RBRACK)) begin
               if (rd_data == CH_NUL) begin
                  thread_end = 1'b1;
               end else begin
                  hit_in   = (c_ff >= lo_ff) && (c_ff <= rd_data);
                  lo_in    = 8'h00;
                  j_in     = j_ff + TWO;
                  rd_addr  = j_ff + TWO;
                  state_in = S_CA;
               end
            end else begin
               lo_in    = pj_ff;
               hit_in   = (c_ff == pj_ff);
               first_in = 1'b0;
               j_in     = j_ff + ONE;
               rd_addr  = j_ff + ONE;
               state_in = S_CA;
            end
         end

         // skip to the closing bracket
         S_CSCAN: begin
            if (rd_data == CH_NUL) begin
               thread_end = 1'b1;
            end else if (rd_data == CH_RBRACK) begin
               if (hit_ff != neg_ff) begin
                  next_in[j_ff + ONE] = 1'b1;
               end
               thread_end = 1'b1;
            end else begin
               j_in    = j_ff + ONE;
               rd_addr = j_ff + ONE;
            end
         end

         // hand the verdict to the output register
         S_DONE: begin
            result.fire    = out_free;
            result.matched = match_ff;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // advance to the next thread or close the word
      if (thread_end) begin
         if (k_ff == LAST_POS) begin
            if (c_ff == CH_NUL) begin
               active_in    = '0;
               active_in[0] = 1'b1;
               start_in     = 1'b1;
               state_in     = S_DONE;
            end else begin
               active_in = next_in;
               start_in  = 1'b0;
               state_in  = S_IDLE;
            end
         end else begin
            k_in     = k_ff + ONE;
            state_in = S_SCAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b1;
         active_ff    <= '0;
         active_ff[0] <= 1'b1;
         match_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         start_ff  <= start_in;
         active_ff <= active_in;
         match_ff  <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      c_ff     <= c_in;
      lo_ff    <= lo_in;
      pj_ff    <= pj_in;
      dot_ff   <= dot_in;
      skip_ff  <= skip_in;
      neg_ff   <= neg_in;
      hit_ff   <= hit_in;
      first_ff <= first_in;
      next_ff  <= next_in;
   end

   assign idle = (state_ff == S_IDLE);

endmodule

/* rtl/glob_pattern_matcher_core.sv */
// Glob pattern matcher core.
// Load a pattern with req_type = 0 words: req_pattern_index selects the store
// position and req_data_byte holds the pattern byte.
// csr_wr_en / csr_wr_data set the number of pattern bytes in use.
// Feed a file name with req_type = 1 words, one byte each, ending in a zero byte.
// Only the zero byte produces a rsp_ word; rsp_matched tells whether the whole
// name matched the pattern.
// A name word sweeps over the active set and steps each active thread over a
// star or plain byte, an escape, or a bracket class (opening it, testing its
// members, skipping bytes and reaching the closing bracket), reading one store
// byte at a time through the single read port; a terminator word then waits in
// the done state. No further word is taken until the name word is through.
// req_ready is high only while the sequencer is idle.
// Reset empties the active set down to position zero, arms the leading-dot rule,
// clears the length register and drops rsp_valid; pattern store contents are not
// cleared and must be written before use.
// A stalled receiver holds the result in the output register; the block takes
// further words meanwhile and stalls only when a second result is ready.
module glob_pattern_matcher_core #(
   parameter int MAX_PATTERN = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_type,
   input  logic [4:0] req_pattern_index,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matched,
   input  logic       csr_wr_en,
   input  logic [gpm_pkg::LEN_W-1:0] csr_wr_data
);
   import gpm_pkg::*;

   localparam int PW = $clog2(MAX_PATTERN + 1);
   localparam int AW = $clog2(MAX_PATTERN);
   localparam int XW = (PW > LEN_W) ? PW : LEN_W;

   logic [LEN_W-1:0] len_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_matched_ff, rsp_matched_in;
   logic [XW-1:0]    len_x, max_x, idx_x;
   logic [PW-1:0]    used;
   logic [PW-1:0]    rd_addr;
   logic [7:0]       rd_data;
   logic             idle;
   logic             req_fire;
   logic             wr_en;
   logic             out_free;
   gpm_cmd_type      cmd;
   gpm_result_type   res;

   // length register
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (csr_wr_en) begin
         len_ff <= csr_wr_data;
      end
   end

   assign len_x = XW'(len_ff);
   assign max_x = XW'(MAX_PATTERN);
   assign idx_x = XW'(req_pattern_index);
   assign used  = (len_x < max_x) ? PW'(len_x) : PW'(max_x);

   // decode the accepted word
   assign req_ready = idle;
   assign req_fire  = req_valid && req_ready;
   assign wr_en     = req_fire && !req_type && (idx_x < max_x);
   assign cmd.start = req_fire && req_type;
   assign cmd.char  = req_data_byte;

   gpm_pat_mem #(
      .DEPTH (MAX_PATTERN),
      .AW    (AW),
      .PW    (PW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(idx_x)),
      .wr_data (req_data_byte),
      .rd_addr (rd_addr),
      .used    (used),
      .rd_data (rd_data)
   );

   gpm_engine #(
      .MAX_PATTERN (MAX_PATTERN),
      .PW          (PW)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .out_free (out_free),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .idle     (idle),
      .result   (res)
   );

   // output register: load on a verdict, drop on take
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_matched_in = rsp_matched_ff;
      if (res.fire) begin
         rsp_valid_in   = 1'b1;
         rsp_matched_in = res.matched;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

   // no verdict overwrites a result the receiver has not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !res.fire)
      else $error("verdict issued while output held");

   // a name word occupies the sequencer
   a_busy_after_name: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_type) |=> !req_ready)
      else $error("ready stayed high after a name word");

   // a new result comes only from a verdict
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(res.fire))
      else $error("output loaded without a verdict");

endmodule

/* sim/gpm_checker.sv */
`timescale 1ns / 1ps
module gpm_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_type,
   input  logic [4:0] req_pattern_index,
   input  logic [7:0] req_data_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_matched,
   input  logic       csr_wr_en,
   input  logic [gpm_pkg::LEN_W-1:0] csr_wr_data,
   output int         fail_count,
   output int         pending_count,
   output int         match_count,
   output int         name_count
);
   import gpm_pkg::*;

   localparam int MAXP = 32;
   localparam logic [MAXP:0] POS_ZERO = {{MAXP{1'b0}}, 1'b1};

   logic [7:0]      pat_mem [MAXP];
   logic [MAXP:0]   live_pos;
   logic            name_start;
   logic [5:0]      pat_len;
   logic            match_queue [$];

   // pattern byte at position j, zero past the used length
   function automatic logic [7:0] pat_at(int j);
      int ulen;
      ulen = (pat_len < MAXP) ? int'(pat_len) : MAXP;
      return (j < ulen) ? pat_mem[j] : CH_NUL;
   endfunction

   // bracket class test starting at '[' in position i
   function automatic logic class_hit(int i, logic [7:0] c, output int close,
                                      output logic ok);
      int j;
      logic neg, hit, first, last;
      logic [7:0] lo;
      j = i + 1; neg = 0; hit = 0; first = 1; lo = 0; ok = 0; close = 0;
      if (pat_at(j) == CH_BANG) begin
         neg = 1;
         j++;
      end
      while (!hit && pat_at(j) != CH_NUL && (first || pat_at(j) != CH_RBRACK)) begin
         last = (pat_at(j + 1) == CH_RBRACK);
         if (pat_at(j) == CH_DASH && lo != 0 && !first && !last) begin
            j++;
            if (pat_at(j) == CH_NUL) return 0;
            hit = (c >= lo) && (c <= pat_at(j));
            lo = 0;
            j++;
         end else begin
            lo = pat_at(j);
            hit = (c == pat_at(j));
            first = 0;
            j++;
         end
      end
      while (pat_at(j) != CH_NUL && pat_at(j) != CH_RBRACK) j++;
      if (pat_at(j) == CH_NUL) return 0;
      ok = 1;
      close = j;
      return hit != neg;
   endfunction

   // advance one thread at position i over byte c
   function automatic void step_thread(int i, logic [7:0] c, logic dot,
                                       ref logic [MAXP:0] nxt);
      logic [7:0] ch;
      int close;
      logic ok, h;
      forever begin
         ch = pat_at(i);
         if (ch == CH_STAR) begin
            if (dot) return;
            if (i <= MAXP) nxt[i] = 1;
            while (pat_at(i) == CH_STAR) i++;
            continue;
         end
         if (ch == CH_QUEST) begin
            if (dot || c == 0) return;
            if (i + 1 <= MAXP) nxt[i + 1] = 1;
            return;
         end
         if (ch == CH_LBRACK) begin
            if (dot || c == 0) return;
            h = class_hit(i, c, close, ok);
            if (h && ok && close + 1 <= MAXP) nxt[close + 1] = 1;
            return;
         end
         if (ch == CH_ESC) begin
            i++;
            ch = pat_at(i);
         end
         if (ch == c) begin
            if (c != 0) begin
               if (i + 1 <= MAXP) nxt[i + 1] = 1;
            end else if (i <= MAXP) nxt[i] = 1;
         end
         return;
      end
   endfunction

   // consume one name word; returns 1 and the verdict on the terminator
   function automatic logic feed_name(logic [7:0] c, output logic verdict);
      logic [MAXP:0] nxt;
      logic dot;
      dot = name_start && c == CH_DOT;
      nxt = '0;
      for (int k = 0; k <= MAXP; k++)
         if (live_pos[k]) step_thread(k, c, dot, nxt);
      live_pos = nxt;
      name_start = 0;
      verdict = 0;
      if (c != 0) return 0;
      for (int k = 0; k <= MAXP; k++)
         if (live_pos[k] && pat_at(k) == CH_NUL) verdict = 1;
      live_pos = POS_ZERO;
      name_start = 1;
      return 1;
   endfunction

   always @(posedge clock) begin
      logic v, got;
      if (reset) begin
         live_pos   = POS_ZERO;
         name_start = 1;
         pat_len    = '0;
         match_queue.delete();
         fail_count    <= 0;
         match_count   <= 0;
         name_count    <= 0;
         pending_count <= 0;
      end else begin
         // compare the result word with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (match_queue.size() == 0) begin
               $error("unexpected result word: matched=%0d", rsp_matched);
               fail_count <= fail_count + 1;
            end else begin
               got = match_queue.pop_front();
               if (got !== rsp_matched) begin
                  $error("matched: expected %0d actual %0d", got, rsp_matched);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_wr_en) pat_len = csr_wr_data;
         // predict the accepted request word
         if (req_valid && req_ready) begin
            if (req_type == 0) pat_mem[req_pattern_index] = req_data_byte;
            else if (feed_name(req_data_byte, v)) begin
               match_queue = {match_queue, v};
               name_count <= name_count + 1;
               if (v) match_count <= match_count + 1;
            end
         end
         pending_count <= match_queue.size();
      end
   end
endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
   import gpm_pkg::*;

   localparam int CYCLE_LIMIT = 20000000;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   logic       req_type = 0;
   logic [4:0] req_pattern_index = 0;
   logic [7:0] req_data_byte = 0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic       rsp_matched;
   logic       csr_wr_en = 0;
   logic [LEN_W-1:0] csr_wr_data = 0;
   int         fail_count, pending_count, match_count, name_count;
   int         cycle_count = 0;
   logic       calm = 0;
   int         sent = 0;
   logic [7:0] cur_pat [32];
   int         cur_len;

   always #6 clock = ~clock;

   glob_pattern_matcher_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_pattern_index(req_pattern_index), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_matched(rsp_matched),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   gpm_checker i_chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_pattern_index(req_pattern_index), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_matched(rsp_matched),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .match_count(match_count), .name_count(name_count)
   );

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver stalls in bursts
   initial begin
      int n;
      forever begin
         rsp_ready <= 1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (!calm) begin
            n = $urandom_range(1, 13);
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end
      end
   end

   // drive one request word and hold until accepted; valid stays up afterward
   task automatic send_word(logic t, logic [4:0] idx, logic [7:0] b);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= t;
      req_pattern_index <= idx;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   // drop valid and wait until every expected result is back
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_length(int n);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= LEN_W'(n);
      @(posedge clock);
      csr_wr_en <= 0;
      cur_len = n;
   endtask

   // write a whole pattern from a string, then set its length
   task automatic load_glob(string s);
      for (int i = 0; i < s.len() && i < 32; i++) begin
         send_word(0, 5'(i), s[i]);
         cur_pat[i] = s[i];
      end
      set_length(s.len() > 32 ? 32 : s.len());
   endtask

   task automatic feed(string s);
      for (int i = 0; i < s.len(); i++) send_word(1, 5'($urandom), s[i]);
      send_word(1, 5'($urandom), 8'h00);
   endtask

   // random glob byte biased toward syntax characters
   function automatic logic [7:0] glob_char();
      case ($urandom_range(0, 11))
         0: return CH_STAR;
         1: return CH_QUEST;
         2: return CH_LBRACK;
         3: return CH_RBRACK;
         4: return CH_ESC;
         5: return CH_BANG;
         6: return CH_DASH;
         7: return CH_DOT;
         8: return 8'($urandom_range(1, 255));
         default: return 8'("a" + $urandom_range(0, 3));
      endcase
   endfunction

   function automatic logic [7:0] name_char();
      case ($urandom_range(0, 5))
         0: return glob_char();
         1: return 8'($urandom_range(1, 255));
         default: return 8'("a" + $urandom_range(0, 3));
      endcase
   endfunction

   initial begin
      int plen, nlen, k;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // fill the whole store so no read ever hits an unwritten entry
      for (int i = 0; i < 32; i++) begin
         send_word(0, 5'(i), "a");
         cur_pat[i] = "a";
      end
      set_length(0);
      feed("");
      feed("a");
      load_glob("*.c");       feed("x.c"); feed(".c"); feed("x.h");
      load_glob("?a[!b-d]");  feed("zae"); feed("zab"); feed(".ae");
      load_glob("[]-]\\*");   feed("]*"); feed("-*");
      load_glob("[a-");       feed("a");
      load_glob("ab\\");      feed("ab");
      load_glob("[\x01-\xff]"); feed("\xff");
      // zero byte inside the used length ends the pattern
      send_word(0, 1, 8'h00); feed("a");
      load_glob("********************************"); feed("abc");
      set_length(63); feed("aa");

      // pause the sender until every result is back
      drain();

      while (sent < 1300) begin
         if (sent > 1150) calm = 1;
         if ($urandom_range(0, 3) == 0) begin
            plen = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32) : $urandom_range(1, 8);
            for (int i = 0; i < plen; i++) begin
               cur_pat[i] = glob_char();
               send_word(0, 5'(i), cur_pat[i]);
            end
            // stray writes to arbitrary positions, all indexes reachable
            if ($urandom_range(0, 4) == 0) begin
               k = $urandom_range(0, 31);
               cur_pat[k] = 8'($urandom);
               send_word(0, 5'(k), cur_pat[k]);
            end
            set_length($urandom_range(0, 9) == 0 ? $urandom_range(33, 63) : plen);
         end
         nlen = $urandom_range(0, 10);
         for (int i = 0; i < nlen; i++) begin
            logic [7:0] b;
            // mostly pattern-shaped names so threads survive
            if ($urandom_range(0, 2) != 0 && i < cur_len && cur_len <= 32
                && cur_pat[i] != 0 && cur_pat[i] != CH_STAR)
               b = cur_pat[i];
            else
               b = name_char();
            if (b == 0) b = "a";
            send_word(1, 5'($urandom), b);
         end
         send_word(1, 5'($urandom), 8'h00);
      end

      drain();
      $display("Ran %0d request words, %0d names checked, %0d of them matched.",
               sent, name_count, match_count);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
